// ===== rtl/dsa_pkg.sv =====
// Shared types and constants of the dedup slot allocator.
// Holds reset values, status codes and the controller/datapath interface structs.
// No dependencies.
package dsa_pkg;

	localparam int DSA_TABLE_DEPTH = 256;
	localparam int DSA_HANDLE_BITS = 32;

	localparam int DSA_CFG_W = 9;
	localparam logic [DSA_CFG_W-1:0] DSA_MAX_SLOTS_RST = 9'd256;
	localparam logic [DSA_CFG_W-1:0] DSA_WARN_RST = 9'd213;

	localparam int DSA_IN_HANDLE_W = 32;
	localparam int DSA_SLOT_W = 8;
	localparam int DSA_STATUS_W = 3;

	localparam logic DSA_CMD_REGISTER = 1'b0;
	localparam logic DSA_CMD_UNREGISTER = 1'b1;

	localparam logic [DSA_STATUS_W-1:0] DSA_ST_EXISTING = 3'd0;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_REUSED = 3'd1;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_APPENDED = 3'd2;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_NULL = 3'd3;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_FULL = 3'd4;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_BADIDX = 3'd5;
	localparam logic [DSA_STATUS_W-1:0] DSA_ST_REMOVED = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} dsa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic quick;
		logic scan_done;
		logic out_free;
	} dsa_stat_t;

endpackage

// ===== rtl/dedup_slot_allocator_core.sv =====
// Top level of the dedup slot allocator: stream ports, APB register file, controller and datapath.
// Depends on dsa_pkg, dsa_ctrl, dsa_datapath (and dsa_ram below it).
//
// The block keeps a table of nonzero handles. A register word searches the used slots for its
// handle and returns that slot, else fills the lowest empty used slot, else appends a slot at
// the used count unless the limit min(max_slots, TABLE_DEPTH) is reached; a zero handle is
// rejected. An unregister word empties a used slot. One word is in work at a time. A register
// word's search reads the table RAM one entry per cycle through its single read port and
// stops early when the handle is found; unregister and null-handle words skip the search.
// The result sits in an output register, so the next word is accepted while an earlier
// result waits on m_tready. The table needs no clearing after reset, since only entries
// below the used count are ever read.
module dedup_slot_allocator_core
	import dsa_pkg::*;
#(
	parameter int TABLE_DEPTH = DSA_TABLE_DEPTH,
	parameter int HANDLE_BITS = DSA_HANDLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // handle [31:0], slot_index [39:32]
	input  logic [0:0]  s_tuser,   // cmd [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot [7:0], status [10:8], near_limit [11],
	                               // table_changed [12], zero [15:13]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_MAX_SLOTS = 1'b0;
	localparam logic REG_WARN = 1'b1;

	logic [DSA_CFG_W-1:0] max_slots_q;
	logic [DSA_CFG_W-1:0] warn_q;
	logic                 cfg_wr;

	dsa_cmd_t  ctrl;
	dsa_stat_t stat;

	logic [DSA_SLOT_W-1:0]   out_slot;
	logic [DSA_STATUS_W-1:0] out_status;
	logic                    out_near_limit;
	logic                    out_table_changed;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q <= DSA_MAX_SLOTS_RST;
			warn_q <= DSA_WARN_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_SLOTS: max_slots_q <= pwdata[DSA_CFG_W-1:0];
				REG_WARN: warn_q <= pwdata[DSA_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_SLOTS: prdata = {{(32-DSA_CFG_W){1'b0}}, max_slots_q};
			REG_WARN: prdata = {{(32-DSA_CFG_W){1'b0}}, warn_q};
			default: prdata = '0;
		endcase
	end

	dsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.ctrl    (ctrl)
	);

	dsa_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_cmd           (s_tuser[0]),
		.in_handle        (s_tdata[31:0]),
		.in_slot_index    (s_tdata[39:32]),
		.max_slots        (max_slots_q),
		.warn_threshold   (warn_q),
		.ctrl             (ctrl),
		.stat             (stat),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_slot         (out_slot),
		.out_status       (out_status),
		.out_near_limit   (out_near_limit),
		.out_table_changed(out_table_changed)
	);

	assign m_tdata = {3'b000, out_table_changed, out_near_limit, out_status, out_slot};

endmodule

// ===== rtl/dsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module dsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dsa_ctrl.sv =====
// Controller state machine of the dedup slot allocator.
// Depends on dsa_pkg for the command and status structs.
module dsa_ctrl
	import dsa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dsa_stat_t stat,
	output dsa_cmd_t  ctrl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DISPATCH = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		ctrl = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = stat.quick ? S_FIN : S_SCAN;
			end
			S_SCAN: begin
				ctrl.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// Hold the finished item until the output register can take it.
				if (stat.out_free) begin
					ctrl.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/dsa_datapath.sv =====
// Datapath of the dedup slot allocator: slot table RAM, scan pipeline, result register.
// Depends on dsa_pkg and dsa_ram.
module dsa_datapath
	import dsa_pkg::*;
#(
	parameter int TABLE_DEPTH = DSA_TABLE_DEPTH,
	parameter int HANDLE_BITS = DSA_HANDLE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_cmd,
	input  logic [DSA_IN_HANDLE_W-1:0] in_handle,
	input  logic [DSA_SLOT_W-1:0]      in_slot_index,
	input  logic [DSA_CFG_W-1:0]       max_slots,
	input  logic [DSA_CFG_W-1:0]       warn_threshold,
	input  dsa_cmd_t                   ctrl,
	output dsa_stat_t                  stat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [DSA_SLOT_W-1:0]      out_slot,
	output logic [DSA_STATUS_W-1:0]    out_status,
	output logic                       out_near_limit,
	output logic                       out_table_changed
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int HW = (HANDLE_BITS < DSA_IN_HANDLE_W) ? HANDLE_BITS : DSA_IN_HANDLE_W;
	localparam int CMPW = (CW > DSA_CFG_W) ? CW : DSA_CFG_W;

	logic              cmd_q;
	logic [HW-1:0]     handle_q;
	logic [DSA_SLOT_W-1:0] idx_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     rd_addr_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic              match_q;
	logic [AW-1:0]     match_idx_q;
	logic              empty_found_q;
	logic [AW-1:0]     empty_idx_q;
	logic              out_valid_q;
	logic [DSA_SLOT_W-1:0]   slot_q;
	logic [DSA_STATUS_W-1:0] status_q;
	logic              near_q;
	logic              changed_q;

	logic [HW-1:0]     rd_data;
	logic              issue;
	logic              hit;
	logic              hole;

	logic [CMPW-1:0]   used_x;
	logic [CMPW-1:0]   idx_x;
	logic [CMPW-1:0]   max_x;
	logic [CMPW-1:0]   depth_x;
	logic [CMPW-1:0]   limit_x;
	logic [CMPW-1:0]   warn_x;

	logic                    res_wr;
	logic [AW-1:0]           res_waddr;
	logic [HW-1:0]           res_wdata;
	logic                    res_bump;
	logic [DSA_SLOT_W-1:0]   res_slot;
	logic [DSA_STATUS_W-1:0] res_status;
	logic                    res_near;
	logic                    res_changed;

	assign issue = ctrl.scan && !match_q && (rd_addr_q < used_q);
	assign hit = rd_valid_s1 && !match_q && (rd_data == handle_q);
	assign hole = rd_valid_s1 && !match_q && !empty_found_q && (rd_data == '0);

	assign stat.quick = (cmd_q == DSA_CMD_UNREGISTER) || (handle_q == '0);
	assign stat.scan_done = !issue && !rd_valid_s1;
	assign stat.out_free = !out_valid_q || out_ready;

	assign used_x = CMPW'(used_q);
	assign idx_x = CMPW'(idx_q);
	assign max_x = CMPW'(max_slots);
	assign depth_x = CMPW'(TABLE_DEPTH);
	assign limit_x = (max_x < depth_x) ? max_x : depth_x;
	assign warn_x = CMPW'(warn_threshold);

	dsa_ram #(
		.WIDTH(HW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ctrl.commit && res_wr),
		.waddr(res_waddr),
		.wdata(res_wdata),
		.re   (issue),
		.raddr(rd_addr_q[AW-1:0]),
		.rdata(rd_data)
	);

	// Outcome of the current item, in order of precedence.
	always_comb begin
		res_wr = 1'b0;
		res_waddr = '0;
		res_wdata = '0;
		res_bump = 1'b0;
		res_slot = '0;
		res_status = DSA_ST_NULL;
		res_near = 1'b0;
		res_changed = 1'b0;
		if (cmd_q == DSA_CMD_UNREGISTER) begin
			res_slot = idx_q;
			if (idx_x >= used_x) begin
				res_status = DSA_ST_BADIDX;
			end else begin
				res_status = DSA_ST_REMOVED;
				res_changed = 1'b1;
				res_wr = 1'b1;
				res_waddr = AW'(idx_q);
			end
		end else if (handle_q == '0) begin
			res_status = DSA_ST_NULL;
		end else if (match_q) begin
			res_status = DSA_ST_EXISTING;
			res_slot = DSA_SLOT_W'(match_idx_q);
		end else if (empty_found_q) begin
			res_status = DSA_ST_REUSED;
			res_slot = DSA_SLOT_W'(empty_idx_q);
			res_wr = 1'b1;
			res_waddr = empty_idx_q;
			res_wdata = handle_q;
		end else if (used_x >= limit_x) begin
			res_status = DSA_ST_FULL;
		end else begin
			res_status = DSA_ST_APPENDED;
			res_slot = DSA_SLOT_W'(used_q);
			res_near = (used_x == warn_x);
			res_changed = 1'b1;
			res_wr = 1'b1;
			res_waddr = AW'(used_q);
			res_wdata = handle_q;
			res_bump = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= in_cmd;
			handle_q <= HW'(in_handle);
			idx_q <= in_slot_index;
		end
		rd_idx_s1 <= rd_addr_q[AW-1:0];
		if (hit) begin
			match_idx_q <= rd_idx_s1;
		end
		if (hole) begin
			empty_idx_q <= rd_idx_s1;
		end
		if (ctrl.commit) begin
			slot_q <= res_slot;
			status_q <= res_status;
			near_q <= res_near;
			changed_q <= res_changed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			rd_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			match_q <= 1'b0;
			empty_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (ctrl.load) begin
				rd_addr_q <= '0;
				match_q <= 1'b0;
				empty_found_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
				if (hit) begin
					match_q <= 1'b1;
				end
				if (hole) begin
					empty_found_q <= 1'b1;
				end
			end
			if (ctrl.commit && res_bump) begin
				used_q <= used_q + 1'b1;
			end
			if (ctrl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_slot = slot_q;
	assign out_status = status_q;
	assign out_near_limit = near_q;
	assign out_table_changed = changed_q;

endmodule

// ===== test/dsa_checker.sv =====
// Scoreboard for the dedup slot allocator: snoops the stream and APB ports, keeps its own
// copy of the slot table and the limits, and checks every result word against it.
// Depends on dsa_pkg.
module dsa_checker
	import dsa_pkg::*;
#(
	parameter logic [2:0] MAX_SLOTS_ADDR = 3'd0,
	parameter logic [2:0] WARN_ADDR = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // handle [31:0], slot_index [39:32]
	input  logic [0:0]  s_tuser,   // cmd [0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // slot [7:0], status [10:8], near_limit [11],
	                               // table_changed [12], zero [15:13]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Laid out so that the packed value matches m_tdata[12:0].
	typedef struct packed {
		logic                    table_changed;
		logic                    near_limit;
		logic [DSA_STATUS_W-1:0] status;
		logic [DSA_SLOT_W-1:0]   slot;
	} slot_result_t;

	logic [DSA_HANDLE_BITS-1:0] handle_copy [DSA_TABLE_DEPTH];
	int unsigned slots_used;
	logic [DSA_CFG_W-1:0] max_slots_cfg;
	logic [DSA_CFG_W-1:0] warn_cfg;
	slot_result_t expected_slots [$];
	int failures;

	assign fail_count = failures;

	function automatic slot_result_t allocate_slot(input logic cmd,
			input logic [DSA_IN_HANDLE_W-1:0] handle, input logic [DSA_SLOT_W-1:0] index);
		slot_result_t r;
		int unsigned n;
		int unsigned lim;
		int hit;
		int hole;
		int i;
		r = '0;
		hit = -1;
		hole = -1;
		n = (slots_used < DSA_TABLE_DEPTH) ? slots_used : DSA_TABLE_DEPTH;
		if (cmd == DSA_CMD_UNREGISTER) begin
			r.slot = index;
			if (index >= n) begin
				r.status = DSA_ST_BADIDX;
			end else begin
				handle_copy[index] = '0;
				r.status = DSA_ST_REMOVED;
				r.table_changed = 1'b1;
			end
			return r;
		end
		if (handle == '0) begin
			r.status = DSA_ST_NULL;
			return r;
		end
		for (i = 0; i < n; i++) begin
			if (hit < 0 && handle_copy[i] == handle)
				hit = i;
			if (hole < 0 && handle_copy[i] == '0)
				hole = i;
		end
		lim = (max_slots_cfg < DSA_TABLE_DEPTH) ? max_slots_cfg : DSA_TABLE_DEPTH;
		if (hit >= 0) begin
			r.slot = DSA_SLOT_W'(hit);
			r.status = DSA_ST_EXISTING;
		end else if (hole >= 0) begin
			// Filling an emptied slot is not reported as a table change.
			handle_copy[hole] = handle;
			r.slot = DSA_SLOT_W'(hole);
			r.status = DSA_ST_REUSED;
		end else if (n >= lim) begin
			r.status = DSA_ST_FULL;
		end else begin
			handle_copy[n] = handle;
			slots_used = n + 1;
			r.slot = DSA_SLOT_W'(n);
			r.status = DSA_ST_APPENDED;
			r.near_limit = (n == warn_cfg);
			r.table_changed = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_result_t want;
		slot_result_t got;
		int i;
		if (!arst_n) begin
			for (i = 0; i < DSA_TABLE_DEPTH; i++)
				handle_copy[i] = '0;
			slots_used = 0;
			max_slots_cfg = DSA_MAX_SLOTS_RST;
			warn_cfg = DSA_WARN_RST;
			expected_slots.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = slot_result_t'(m_tdata[12:0]);
				if (expected_slots.size() == 0) begin
					if (failures < 10)
						$display("%0t: result word %h arrived with nothing expected",
							$realtime, m_tdata);
					failures++;
				end else begin
					want = expected_slots.pop_front();
					if (got != want || m_tdata[15:13] != '0) begin
						if (failures < 10) begin
							$write("%0t: expected slot %0d status %0d near %0b changed %0b,",
								$realtime, want.slot, want.status, want.near_limit,
								want.table_changed);
							$display(" got slot %0d status %0d near %0b changed %0b pad %b",
								got.slot, got.status, got.near_limit,
								got.table_changed, m_tdata[15:13]);
						end
						failures++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_slots.insert(expected_slots.size(),
					allocate_slot(s_tuser[0], s_tdata[31:0], s_tdata[39:32]));
			if (psel && penable && pwrite && pready) begin
				if (paddr == MAX_SLOTS_ADDR)
					max_slots_cfg = pwdata[DSA_CFG_W-1:0];
				else if (paddr == WARN_ADDR)
					warn_cfg = pwdata[DSA_CFG_W-1:0];
			end
			pending <= expected_slots.size();
		end
	end

endmodule

// ===== test/tb_dedup_slot_allocator_core.sv =====
// Testbench top of the dedup slot allocator: clock, reset, APB limit writes and stream
// stimulus, with random idling on both sides; the verdict comes from dsa_checker.
// Depends on dsa_pkg, dsa_checker and dedup_slot_allocator_core.
module tb_dedup_slot_allocator_core;
	import dsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] MAX_SLOTS_ADDR = 3'd0;
	localparam logic [2:0] WARN_ADDR = 3'd4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // handle [31:0], slot_index [39:32]
	logic [0:0]  s_tuser = '0;   // cmd [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // slot [7:0], status [10:8], near_limit [11],
	                             // table_changed [12], zero [15:13]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int words_sent = 0;
	int src_idle_pct = 21;
	int snk_idle_pct = 68;

	dedup_slot_allocator_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	dsa_checker #(.MAX_SLOTS_ADDR(MAX_SLOTS_ADDR), .WARN_ADDR(WARN_ADDR)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle_pct);

	initial begin
		#20ms;
		$display("tb_dedup_slot_allocator_core NOT OK");
		$finish;
	end

	// Offers one word, possibly after idle cycles, and returns at the edge that takes it.
	// Valid stays high on return so that back-to-back words need no second assignment.
	task automatic push_word(input logic cmd, input logic [31:0] handle,
			input logic [7:0] index);
		if (words_sent < 480) begin
			src_idle_pct = 21;
			snk_idle_pct = 68;
		end else if (words_sent < 960) begin
			src_idle_pct = 68;
			snk_idle_pct = 21;
		end else begin
			src_idle_pct = 0;
			snk_idle_pct = 0;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {index, handle};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(input int max_slots, input int warn_at);
		drain_results();
		apb_write(MAX_SLOTS_ADDR, 32'(max_slots));
		apb_write(WARN_ADDR, 32'(warn_at));
	endtask

	// Mostly registrations, either from a small pool so that lookups hit or of fresh handles,
	// mixed with unregisters mostly aimed at the used range and a few null handles.
	task automatic random_words(input int count, input int fresh_pct, input int span,
			input int pause_at);
		logic [31:0] pool [16];
		int k;
		int r;
		for (k = 0; k < 16; k++)
			pool[k] = $urandom() | 32'h1;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 6)
				push_word(DSA_CMD_REGISTER, '0, 8'($urandom()));
			else if (r < 26)
				push_word(DSA_CMD_UNREGISTER, $urandom(),
					($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(span)));
			else if ($urandom_range(99) < fresh_pct)
				push_word(DSA_CMD_REGISTER, $urandom(), 8'($urandom()));
			else
				push_word(DSA_CMD_REGISTER, pool[$urandom_range(15)], 8'($urandom()));
			if (k == pause_at)
				drain_results();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// A single slot with the warning on slot zero: null, bad index, append, existing, full, removal and reuse.
		set_limits(1, 0);
		push_word(DSA_CMD_REGISTER, 32'h0, 8'hFF);
		push_word(DSA_CMD_UNREGISTER, 32'hFFFF_FFFF, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'h1, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'h1, 8'hFF);
		push_word(DSA_CMD_REGISTER, 32'hFFFF_FFFF, 8'h00);
		push_word(DSA_CMD_UNREGISTER, 32'h0, 8'hFF);
		push_word(DSA_CMD_UNREGISTER, 32'h0, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'hFFFF_FFFF, 8'h5A);
		push_word(DSA_CMD_REGISTER, 32'h1, 8'hA5);
		push_word(DSA_CMD_UNREGISTER, 32'h1, 8'h01);

		set_limits(3, 2);
		push_word(DSA_CMD_REGISTER, 32'h1, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'hA5A5_A5A5, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'h5A5A_5A5A, 8'hFF);
		push_word(DSA_CMD_UNREGISTER, 32'h0, 8'h01);
		push_word(DSA_CMD_UNREGISTER, 32'h0, 8'h01);
		push_word(DSA_CMD_REGISTER, 32'hFFFF_FFFF, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'h5A5A_5A5A, 8'h00);
		push_word(DSA_CMD_REGISTER, 32'h8000_0000, 8'h80);
		push_word(DSA_CMD_UNREGISTER, 32'h0, 8'h03);

		set_limits(6, 4);
		random_words(300, 30, 5, -1);
		set_limits(48, $urandom_range(12, 40));
		random_words(400, 40, 47, 200);
		set_limits(256, 150);
		random_words(450, 65, 255, -1);
		set_limits(256, 256);
		random_words(280, 50, 255, -1);

		drain_results();
		if (fail_count == 0 && pending == 0)
			$display("tb_dedup_slot_allocator_core OK");
		else
			$display("tb_dedup_slot_allocator_core NOT OK");
		$finish;
	end

endmodule
